@@ hw/rtl/tcs_pkg.sv @@
package tcs_pkg;

   localparam int unsigned ByteWidth     = 8;
   localparam int unsigned DigitCntWidth = 3;
   localparam int unsigned Utf8CntWidth  = 2;

   localparam logic [DigitCntWidth-1:0] MaxDigitRunReset = 3'd3;

   localparam logic [ByteWidth-1:0] ChTab   = 8'h09;
   localparam logic [ByteWidth-1:0] ChLf    = 8'h0A;
   localparam logic [ByteWidth-1:0] ChCr    = 8'h0D;
   localparam logic [ByteWidth-1:0] ChSpace = 8'h20;

   typedef enum logic [2:0] {
      MODE_START   = 3'd0,
      MODE_SPACE   = 3'd1,
      MODE_NEWLINE = 3'd2,
      MODE_LETTER  = 3'd3,
      MODE_DIGIT   = 3'd4
   } chunk_mode_type;

   typedef struct packed {
      chunk_mode_type             mode;
      logic [Utf8CntWidth-1:0]    utf8_left;
      logic [DigitCntWidth-1:0]   digit_count;
   } chunk_state_type;

   localparam chunk_state_type ChunkStateReset = '{
      mode:        MODE_START,
      utf8_left:   '0,
      digit_count: '0
   };

   function automatic logic is_blank(input logic [ByteWidth-1:0] b);
      return (b == ChSpace) || (b == ChTab);
   endfunction

   function automatic logic is_newline(input logic [ByteWidth-1:0] b);
      return (b == ChLf) || (b == ChCr);
   endfunction

   function automatic logic is_digit(input logic [ByteWidth-1:0] b);
      return (b >= 8'h30) && (b <= 8'h39);
   endfunction

   function automatic logic is_letter(input logic [ByteWidth-1:0] b);
      return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A)) || b[7];
   endfunction

   // number of UTF-8 continuation bytes owed by a lead byte
   function automatic logic [Utf8CntWidth-1:0] trail_count(input logic [ByteWidth-1:0] b);
      logic [Utf8CntWidth-1:0] n;
      n = '0;
      if ((b & 8'hE0) == 8'hC0) begin
         n = 2'd1;
      end else if ((b & 8'hF0) == 8'hE0) begin
         n = 2'd2;
      end else if ((b & 8'hF8) == 8'hF0) begin
         n = 2'd3;
      end
      return n;
   endfunction

endpackage

@@ hw/rtl/tcs_chunk_rules.sv @@
module tcs_chunk_rules (
   input  logic [tcs_pkg::ByteWidth-1:0]     byte_in,
   input  logic                              last_in,
   input  logic [tcs_pkg::DigitCntWidth-1:0] max_digit_run,
   input  tcs_pkg::chunk_state_type          cur_state,
   output tcs_pkg::chunk_state_type          nxt_state,
   output logic                              chunk_start
);
   import tcs_pkg::*;

   logic [DigitCntWidth-1:0] limit;
   chunk_state_type          class_state;
   chunk_state_type          open_state;

   assign limit = (max_digit_run == '0) ? DigitCntWidth'(1) : max_digit_run;

   // class decided by a byte that is not part of a blank run
   always_comb begin
      class_state = ChunkStateReset;
      if (is_newline(byte_in)) begin
         class_state.mode = MODE_NEWLINE;
      end else if (is_letter(byte_in)) begin
         class_state.mode      = MODE_LETTER;
         class_state.utf8_left = trail_count(byte_in);
      end else if (is_digit(byte_in)) begin
         class_state.mode        = MODE_DIGIT;
         class_state.digit_count = DigitCntWidth'(1);
      end
   end

   always_comb begin
      open_state = class_state;
      if (is_blank(byte_in)) begin
         open_state      = ChunkStateReset;
         open_state.mode = MODE_SPACE;
      end
   end

   always_comb begin
      nxt_state   = cur_state;
      chunk_start = 1'b0;
      if (cur_state.mode == MODE_LETTER && cur_state.utf8_left != '0) begin
         nxt_state.utf8_left = cur_state.utf8_left - Utf8CntWidth'(1);
      end else if (cur_state.mode == MODE_SPACE) begin
         if (!is_blank(byte_in)) begin
            nxt_state = class_state;
         end
      end else if (cur_state.mode == MODE_NEWLINE && is_newline(byte_in)) begin
         nxt_state = cur_state;
      end else if (cur_state.mode == MODE_LETTER && is_letter(byte_in)) begin
         nxt_state.utf8_left = trail_count(byte_in);
      end else if (cur_state.mode == MODE_DIGIT && is_digit(byte_in)
                   && cur_state.digit_count < limit) begin
         nxt_state.digit_count = cur_state.digit_count + DigitCntWidth'(1);
      end else begin
         chunk_start = 1'b1;
         nxt_state   = open_state;
      end
      if (last_in) begin
         nxt_state = ChunkStateReset;
      end
   end

endmodule

@@ hw/rtl/text_chunk_splitter_core.sv @@
// Text chunk splitter core.
// Input stream (req_*): one text byte per transaction in req_tdata, req_tlast
// marks the final byte of a text. Output stream (rsp_*): the same byte in
// rsp_tdata, rsp_tuser = 1 when that byte opens a new chunk, rsp_tlast copied.
// Exactly one output transaction per input transaction, in order.
// Chunk rules: blanks join the following chunk, CR/LF runs, letter runs
// (bytes >= 0x80 count as letters, UTF-8 leads swallow their trail bytes),
// digit runs up to csr max, any other byte alone.
// Two register stages: an input register, then the chunk decision logic,
// then the output register. rsp_tvalid rises once a byte moves on from the
// input register into the output register, so no byte goes straight through.
// Throughput is one byte per cycle while rsp_tready is high, no gap needed.
// A stalled rsp_tready holds the output register; the input register still
// takes one more byte, after which req_tready drops until space frees up.
// reset (synchronous, active high) empties both stages, returns the chunk
// state to chunk start and sets the digit limit to 3. csr_wr_en writes the
// digit limit (0 acts as 1); write it only while the core is idle.
// After a byte with tlast, the chunk state returns to chunk start.
module text_chunk_splitter_core (
   input  logic                              clock,
   input  logic                              reset,
   // input stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [tcs_pkg::ByteWidth-1:0]     req_tdata,   // [7:0] byte_in
   input  logic                              req_tlast,   // last_in
   // output stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [tcs_pkg::ByteWidth-1:0]     rsp_tdata,   // [7:0] byte_out
   output logic                              rsp_tuser,   // [0] chunk_start
   output logic                              rsp_tlast,   // last_out
   // configuration
   input  logic                              csr_wr_en,
   input  logic [tcs_pkg::DigitCntWidth-1:0] csr_wr_data  // max_digit_run
);
   import tcs_pkg::*;

   // input stage
   logic                 in_valid_ff, in_valid_in;
   logic [ByteWidth-1:0] in_byte_ff;
   logic                 in_last_ff;

   // output stage
   logic                 out_valid_ff, out_valid_in;
   logic [ByteWidth-1:0] out_byte_ff;
   logic                 out_start_ff;
   logic                 out_last_ff;

   // chunk state and config
   chunk_state_type          state_ff, state_in;
   logic [DigitCntWidth-1:0] max_run_ff, max_run_in;

   logic out_ready;   // output stage can take a byte this cycle
   logic advance;     // input stage moves into output stage
   logic req_accept;
   logic start_bit;

   assign out_ready  = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_ready;
   assign req_tready = !in_valid_ff || out_ready;
   assign req_accept = req_tvalid && req_tready;

   tcs_chunk_rules u_rules (
      .byte_in       (in_byte_ff),
      .last_in       (in_last_ff),
      .max_digit_run (max_run_ff),
      .cur_state     (state_ff),
      .nxt_state     (state_in),
      .chunk_start   (start_bit)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end

      max_run_in = csr_wr_en ? csr_wr_data : max_run_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= ChunkStateReset;
         max_run_ff   <= MaxDigitRunReset;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         max_run_ff   <= max_run_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance) begin
         out_byte_ff  <= in_byte_ff;
         out_start_ff <= start_bit;
         out_last_ff  <= in_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = out_start_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

@@ hw/rtl/tcs_checker.sv @@
module tcs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [tcs_pkg::ByteWidth-1:0] rsp_tdata,
   input logic                          rsp_tuser,
   input logic                          rsp_tlast
);
   import tcs_pkg::*;

   // set when the next output transaction is the first byte of a text
   logic text_head_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         text_head_ff <= 1'b1;
      end else if (rsp_tvalid && rsp_tready) begin
         text_head_ff <= rsp_tlast;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp transaction changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid after reset");

   a_text_head_starts: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && text_head_ff |-> rsp_tuser)
      else $error("first byte of a text without chunk start");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req_tready low with empty output stage");

endmodule

bind text_chunk_splitter_core tcs_checker u_tcs_checker (.*);

@@ dv/testbench.sv @@
// Stream-level check of text_chunk_splitter_core. Each accepted input
// transaction is run through a local model of the chunk rules, and each
// output transaction is compared against the oldest predicted tagged byte.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tcs_pkg::*;

   localparam int unsigned CycleLimit    = 200000;
   localparam int unsigned LongStallLen  = 300;
   localparam int unsigned RandomBytes   = 200;   // per random phase
   localparam int unsigned MaxReports    = 10;

   // one byte of text waiting to go in, and one predicted output
   typedef struct packed {
      logic [ByteWidth-1:0] data;
      logic                 last;
   } text_byte_type;

   typedef struct packed {
      logic [ByteWidth-1:0] data;
      logic                 start;
      logic                 last;
   } tagged_byte_type;

   typedef enum logic [2:0] {
      BC_BLANK, BC_NEWLINE, BC_LETTER, BC_DIGIT, BC_OTHER
   } byte_class_type;

   // directed text, {last, byte}
   localparam logic [8:0] DirectedText [26] = '{
      {1'b0, 8'h20}, {1'b0, 8'h09}, {1'b0, 8'h48}, {1'b0, 8'h69},  // blanks join word
      {1'b0, 8'h20}, {1'b0, 8'h2C}, {1'b0, 8'h21},                 // blank + punct, lone punct
      {1'b0, 8'h0D}, {1'b0, 8'h0A},                                // newline run
      {1'b0, 8'h31}, {1'b0, 8'h32}, {1'b0, 8'h33}, {1'b0, 8'h34},  // digit run overflows at 3
      {1'b0, 8'hC3}, {1'b0, 8'h20},                                // 2-byte lead eats a blank
      {1'b0, 8'hE2}, {1'b0, 8'h31}, {1'b0, 8'h0A},                 // 3-byte lead eats anything
      {1'b0, 8'hF0}, {1'b0, 8'h9F}, {1'b0, 8'h98}, {1'b0, 8'h80},  // 4-byte sequence
      {1'b0, 8'hFF}, {1'b0, 8'h00},                                // extremes
      {1'b1, 8'hE2},                                               // last cuts a sequence
      {1'b1, 8'h82}                                                // fresh text after last
   };

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [ByteWidth-1:0]     req_tdata = '0;
   logic                     req_tlast = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [ByteWidth-1:0]     rsp_tdata;
   logic                     rsp_tuser;
   logic                     rsp_tlast;
   logic                     csr_wr_en = 1'b0;
   logic [DigitCntWidth-1:0] csr_wr_data = '0;

   text_byte_type   text_q [$];      // bytes not yet offered
   tagged_byte_type tagged_q [$];    // predicted outputs in order
   text_byte_type   next_item;
   tagged_byte_type want_tag, got_tag;

   // model state
   chunk_mode_type           mode_q;
   logic [Utf8CntWidth-1:0]  utf8_owed;
   logic [DigitCntWidth-1:0] digit_run;
   logic [DigitCntWidth-1:0] digit_limit;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   logic        req_taken = 1'b0;
   logic        long_stall_req = 1'b0;
   int unsigned stall_cycles = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;

   text_chunk_splitter_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Chunk rule model
   // ---------------------------------------------------------------------
   function automatic text_byte_type text_byte(input logic [ByteWidth-1:0] d, input logic l);
      text_byte_type t;
      t.data = d;
      t.last = l;
      return t;
   endfunction

   function automatic byte_class_type classify(input logic [ByteWidth-1:0] b);
      if (b == ChSpace || b == ChTab) return BC_BLANK;
      if (b == ChLf || b == ChCr) return BC_NEWLINE;
      // bytes with the top bit set count as letters
      if ((b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) || b[7]) return BC_LETTER;
      if (b >= 8'h30 && b <= 8'h39) return BC_DIGIT;
      return BC_OTHER;
   endfunction

   // continuation bytes a UTF-8 lead pulls in
   function automatic logic [Utf8CntWidth-1:0] utf8_trail_len(input logic [ByteWidth-1:0] b);
      casez (b)
         8'b110?????: return 2'd1;
         8'b1110????: return 2'd2;
         8'b11110???: return 2'd3;
         default:     return 2'd0;
      endcase
   endfunction

   task automatic clear_chunk_state();
      mode_q    = MODE_START;
      utf8_owed = '0;
      digit_run = '0;
   endtask

   // the byte that fixes a chunk's class (never a blank)
   task automatic take_class(input logic [ByteWidth-1:0] b, input byte_class_type cls);
      utf8_owed = '0;
      digit_run = '0;
      case (cls)
         BC_NEWLINE: mode_q = MODE_NEWLINE;
         BC_LETTER: begin
            mode_q    = MODE_LETTER;
            utf8_owed = utf8_trail_len(b);
         end
         BC_DIGIT: begin
            mode_q    = MODE_DIGIT;
            digit_run = 3'd1;
         end
         default: mode_q = MODE_START;
      endcase
   endtask

   task automatic split_byte(input text_byte_type item, output tagged_byte_type tag);
      byte_class_type           cls;
      logic [DigitCntWidth-1:0] limit;
      logic                     start;
      cls   = classify(item.data);
      limit = (digit_limit == '0) ? 3'd1 : digit_limit;
      start = 1'b0;
      if (mode_q == MODE_LETTER && utf8_owed != '0) begin
         utf8_owed = utf8_owed - 2'd1;
      end else if (mode_q == MODE_SPACE) begin
         // blank run: the first non-blank stays in the chunk and sets its class
         if (cls != BC_BLANK) take_class(item.data, cls);
      end else if (mode_q == MODE_NEWLINE && cls == BC_NEWLINE) begin
         // newline run goes on
      end else if (mode_q == MODE_LETTER && cls == BC_LETTER) begin
         utf8_owed = utf8_trail_len(item.data);
      end else if (mode_q == MODE_DIGIT && cls == BC_DIGIT && digit_run < limit) begin
         digit_run = digit_run + 3'd1;
      end else begin
         start = 1'b1;
         if (cls == BC_BLANK) begin
            mode_q    = MODE_SPACE;
            utf8_owed = '0;
            digit_run = '0;
         end else begin
            take_class(item.data, cls);
         end
      end
      if (item.last) clear_chunk_state();
      tag = '{data: item.data, start: start, last: item.last};
   endtask

   // ---------------------------------------------------------------------
   // Driver: offers queued bytes at the falling edge, holds until taken
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (text_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            next_item = text_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= next_item.data;
            req_tlast  <= next_item.last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver ready: random back-pressure, plus one long hold-off on request
   always @(negedge clock) begin
      if (long_stall_req && stall_cycles < LongStallLen) begin
         stall_cycles <= stall_cycles + 1;
         rsp_tready   <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: tracks the config register, predicts on input transactions,
   // checks output transactions (check first; no result can come out the
   // same edge its byte goes in)
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         clear_chunk_state();
         digit_limit = MaxDigitRunReset;
         req_taken <= 1'b0;
      end else begin
         if (csr_wr_en) digit_limit = csr_wr_data;
         req_taken <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            got_tag = '{data: rsp_tdata, start: rsp_tuser, last: rsp_tlast};
            if (tagged_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MaxReports)
                  $display("unexpected rsp transaction: data %02h start %0b last %0b",
                           got_tag.data, got_tag.start, got_tag.last);
            end else begin
               want_tag = tagged_q.pop_front();
               if (got_tag !== want_tag) begin
                  mismatch_count++;
                  if (mismatch_count <= MaxReports)
                     $display("rsp mismatch: expected data %02h start %0b last %0b, %s %02h %0b %0b",
                              want_tag.data, want_tag.start, want_tag.last, "got",
                              got_tag.data, got_tag.start, got_tag.last);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            split_byte(text_byte(req_tdata, req_tlast), want_tag);
            tagged_q = {tagged_q, want_tag};
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   // wait until every byte is sent and every prediction consumed, then let
   // the two pipeline stages settle
   task automatic wait_drained();
      do @(posedge clock);
      while (text_q.size() != 0 || req_tvalid || tagged_q.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_digit_limit(input logic [DigitCntWidth-1:0] value);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   // one text built from mostly well-formed tokens, with some noise and
   // broken UTF-8; returns the number of bytes queued
   task automatic queue_random_text(output int unsigned n_bytes);
      text_byte_type    buf_q [$];
      int unsigned      target, kind, run, trails, k;
      logic [7:0]       b;
      target = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 16);
      while (buf_q.size() < target) begin
         kind = $urandom_range(0, 99);
         if (kind < 25) begin
            run = $urandom_range(1, 8);
            for (k = 0; k < run; k++) begin
               b = 8'($urandom_range(0, 51));
               b = (b < 8'd26) ? 8'h41 + b : 8'h61 + b - 8'd26;
               buf_q = {buf_q, text_byte(b, 1'b0)};
            end
         end else if (kind < 40) begin
            run = $urandom_range(1, 3);
            for (k = 0; k < run; k++)
               buf_q = {buf_q, text_byte($urandom_range(0, 1) ? ChSpace : ChTab, 1'b0)};
         end else if (kind < 50) begin
            run = $urandom_range(1, 3);
            for (k = 0; k < run; k++)
               buf_q = {buf_q, text_byte($urandom_range(0, 1) ? ChLf : ChCr, 1'b0)};
         end else if (kind < 65) begin
            run = $urandom_range(1, 9);
            for (k = 0; k < run; k++)
               buf_q = {buf_q, text_byte(8'(8'h30 + $urandom_range(0, 9)), 1'b0)};
         end else if (kind < 78) begin
            trails = $urandom_range(1, 3);
            case (trails)
               1: b = 8'hC0 | 8'($urandom_range(0, 31));
               2: b = 8'hE0 | 8'($urandom_range(0, 15));
               default: b = 8'hF0 | 8'($urandom_range(0, 7));
            endcase
            buf_q = {buf_q, text_byte(b, 1'b0)};
            // now and then a truncated sequence
            if ($urandom_range(0, 9) == 0) trails = $urandom_range(0, trails - 1);
            for (k = 0; k < trails; k++) begin
               b = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'h80 | 8'($urandom_range(0, 63));
               buf_q = {buf_q, text_byte(b, 1'b0)};
            end
         end else if (kind < 90) begin
            do b = 8'($urandom_range(0, 127));
            while (classify(b) != BC_OTHER);
            buf_q = {buf_q, text_byte(b, 1'b0)};
         end else begin
            // raw noise, sometimes ending a text early
            buf_q = {buf_q, text_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0)};
         end
      end
      buf_q[buf_q.size() - 1].last = 1'b1;
      n_bytes = buf_q.size();
      text_q = {text_q, buf_q};
   endtask

   task automatic run_random_phase(input int unsigned s_idle, input int unsigned r_idle);
      int unsigned queued, n;
      @(posedge clock);
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      queued = 0;
      while (queued < RandomBytes) begin
         queue_random_text(n);
         queued += n;
      end
      wait_drained();
   endtask

   initial begin
      repeat (3) @(negedge clock);
      reset = 1'b0;
      @(posedge clock);

      // directed text at the reset digit limit
      send_idle_pct = 25;
      recv_idle_pct = 67;
      foreach (DirectedText[i])
         text_q = {text_q, text_byte(DirectedText[i][7:0], DirectedText[i][8])};
      wait_drained();

      write_digit_limit(3'd0);          // acts as a limit of one
      run_random_phase(25, 67);
      write_digit_limit(3'd7);
      run_random_phase(67, 25);

      // no idling; the receiver holds off long enough to back up the input
      write_digit_limit(3'd1);
      @(posedge clock);
      long_stall_req = 1'b1;
      run_random_phase(0, 0);

      write_digit_limit(DigitCntWidth'($urandom_range(2, 6)));
      run_random_phase(0, 0);

      wait_drained();
      if (mismatch_count == 0 && tagged_q.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/tcs_pkg.sv
hw/rtl/tcs_chunk_rules.sv
hw/rtl/text_chunk_splitter_core.sv
hw/rtl/tcs_checker.sv
dv/testbench.sv
